FILE: design/pcdd_pkg.sv
// Shared types and constants for the pulse-count dimming driver.
// Used by the front, queue, back and top-level modules; no dependencies.
package pcdd_pkg;

  localparam int LEVEL_W = 6;
  localparam int HOLD_W  = 12;
  localparam int REM_W   = 7;
  localparam int SHIFT_W = 13;
  localparam int KCNT_W  = 3;

  localparam logic [LEVEL_W-1:0] MAX_STEPS  = 6'd32;
  localparam logic [LEVEL_W-1:0] STEP_RESET = 6'd16;
  localparam logic [LEVEL_W-1:0] LEVEL_DARK = 6'd0;

  localparam logic [HOLD_W-1:0] HOLD_OFF_US    = 12'd3000;
  localparam logic [HOLD_W-1:0] HOLD_ENABLE_US = 12'd30;
  localparam logic [HOLD_W-1:0] HOLD_NONE      = 12'd0;

  // Highest shift of the step count in the remainder sweep
  localparam logic [KCNT_W-1:0] KCNT_TOP  = 3'd6;
  localparam logic [KCNT_W-1:0] KCNT_LAST = 3'd0;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [QCNT_W-1:0] QCNT_FULL  = 2'd2;
  localparam logic [QCNT_W-1:0] QCNT_EMPTY = 2'd0;

  localparam logic [2:0] CFG_REG_STEP = 3'd0;

  typedef enum logic [1:0] {
    CMD_SET = 2'd0,
    CMD_ON  = 2'd1,
    CMD_OFF = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    PK_STATUS = 2'd0,
    PK_OFF    = 2'd1,
    PK_DIM    = 2'd2
  } plan_kind_t;

  typedef struct packed {
    plan_kind_t         kind;
    logic               status;
    logic               enable;
    logic [LEVEL_W-1:0] pulses;
  } plan_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    F_IDLE = 2'd0,
    F_MOD  = 2'd1,
    F_PUSH = 2'd2
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE   = 3'd0,
    B_SINGLE = 3'd1,
    B_OFF    = 3'd2,
    B_ENABLE = 3'd3,
    B_LOW    = 3'd4,
    B_HIGH   = 3'd5
  } back_state_t;

endpackage

FILE: design/pcdd_queue.sv
// Two-entry plan queue between the command front end and the pin sequencer.
// Depends on pcdd_pkg for the plan type and queue sizes.
module pcdd_queue import pcdd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  plan_t   push_plan,
  input  logic    pop,
  output plan_t   pop_plan,
  output q_stat_t q_stat
);

  plan_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= QCNT_EMPTY;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_plan;
    end
  end

  assign pop_plan     = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == QCNT_FULL);
  assign q_stat.empty = (cnt_r == QCNT_EMPTY);

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!q_stat.full || pop))
    else $error("plan pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("plan popped from empty queue");

endmodule

FILE: design/pcdd_front.sv
// Command front end: accepts commands, tracks the stored level and builds a plan.
// The pulse count remainder is found by a seven-step shift-subtract sweep.
// Depends on pcdd_pkg.
module pcdd_front import pcdd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [1:0]         in_cmd,
  input  logic [LEVEL_W-1:0] in_target,
  input  logic [LEVEL_W-1:0] step_count,
  input  q_stat_t            q_stat,
  output logic               push,
  output plan_t              push_plan
);

  front_state_t       st_r, st_nxt;
  logic [LEVEL_W-1:0] cur_r, cur_nxt;
  plan_t              plan_r, plan_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [KCNT_W-1:0]  k_r, k_nxt;

  logic [LEVEL_W-1:0] steps;
  logic               cur_zero;
  logic               act;
  logic [LEVEL_W-1:0] tgt;
  logic [LEVEL_W-1:0] level;
  logic [REM_W-1:0]   span;
  logic [SHIFT_W-1:0] shifted;
  logic [SHIFT_W-1:0] rem_ext;
  logic [SHIFT_W-1:0] rem_sub;
  logic               accept;

  assign steps    = (step_count > MAX_STEPS) ? MAX_STEPS : step_count;
  assign cur_zero = (cur_r == LEVEL_DARK);
  assign accept   = (st_r == F_IDLE) && in_tvalid;

  // Map on and off onto a set with an implied target
  always_comb begin
    act = 1'b0;
    tgt = LEVEL_DARK;
    case (in_cmd)
      CMD_SET: begin
        act = 1'b1;
        tgt = in_target;
      end
      CMD_ON: begin
        act = cur_zero;
        tgt = steps;
      end
      CMD_OFF: begin
        act = !cur_zero;
        tgt = LEVEL_DARK;
      end
      default: begin
        act = 1'b0;
        tgt = LEVEL_DARK;
      end
    endcase
  end

  assign level   = cur_zero ? steps : cur_r;
  assign span    = {1'b0, steps} + {1'b0, level} - {1'b0, tgt};
  assign shifted = {{(SHIFT_W-LEVEL_W){1'b0}}, steps} << k_r;
  assign rem_ext = {{(SHIFT_W-REM_W){1'b0}}, rem_r};
  assign rem_sub = rem_ext - shifted;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      F_IDLE: begin
        if (accept) begin
          if (act && (tgt <= steps) && (tgt != LEVEL_DARK)) begin
            st_nxt = F_MOD;
          end else begin
            st_nxt = F_PUSH;
          end
        end
      end
      F_MOD: begin
        if (k_r == KCNT_LAST) begin
          st_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_stat.full) begin
          st_nxt = F_IDLE;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (st_r == F_IDLE);
    push      = (st_r == F_PUSH) && !q_stat.full;
    push_plan = plan_r;
    push_plan.pulses = rem_r[LEVEL_W-1:0];
    cur_nxt   = cur_r;
    plan_nxt  = plan_r;
    rem_nxt   = rem_r;
    k_nxt     = k_r;
    case (st_r)
      F_IDLE: begin
        if (accept) begin
          plan_nxt.status = 1'b0;
          plan_nxt.enable = 1'b0;
          plan_nxt.pulses = '0;
          rem_nxt         = '0;
          k_nxt           = KCNT_TOP;
          if (!act) begin
            plan_nxt.kind = PK_STATUS;
          end else if (tgt > steps) begin
            plan_nxt.kind   = PK_STATUS;
            plan_nxt.status = 1'b1;
          end else if (tgt == LEVEL_DARK) begin
            plan_nxt.kind = PK_OFF;
            cur_nxt       = LEVEL_DARK;
          end else begin
            plan_nxt.kind   = PK_DIM;
            plan_nxt.enable = cur_zero;
            rem_nxt         = span;
            cur_nxt         = tgt;
          end
        end
      end
      F_MOD: begin
        // Subtract the shifted step count where it fits
        if (rem_ext >= shifted) begin
          rem_nxt = rem_sub[REM_W-1:0];
        end
        k_nxt = k_r - 1'b1;
      end
      default: begin
        k_nxt = k_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= F_IDLE;
      cur_r <= LEVEL_DARK;
    end else begin
      st_r  <= st_nxt;
      cur_r <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    plan_r <= plan_nxt;
    rem_r  <= rem_nxt;
    k_r    <= k_nxt;
  end

  a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= MAX_STEPS)
    else $error("stored level above maximum step count");

endmodule

FILE: design/pcdd_back.sv
// Pin sequencer: pops plans and emits one pin action or status per cycle
// unless stalled, into an output register. Depends on pcdd_pkg.
module pcdd_back import pcdd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  q_stat_t           q_stat,
  input  plan_t             pop_plan,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic              out_drives,
  output logic              out_pin,
  output logic [HOLD_W-1:0] out_hold,
  output logic              out_status,
  output logic              out_last
);

  back_state_t        st_r, st_nxt;
  logic [LEVEL_W-1:0] cnt_r, cnt_nxt;
  logic               sts_r, sts_nxt;
  logic               vld_r, vld_nxt;
  logic               drv_r, drv_nxt;
  logic               pin_r, pin_nxt;
  logic [HOLD_W-1:0]  hold_r, hold_nxt;
  logic               ost_r, ost_nxt;
  logic               last_r, last_nxt;

  logic ld;
  logic emit;

  assign ld = !vld_r || out_tready;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          case (pop_plan.kind)
            PK_OFF: st_nxt = B_OFF;
            PK_DIM: begin
              if (pop_plan.enable) begin
                st_nxt = B_ENABLE;
              end else if (pop_plan.pulses != '0) begin
                st_nxt = B_LOW;
              end else begin
                st_nxt = B_SINGLE;
              end
            end
            default: st_nxt = B_SINGLE;
          endcase
        end
      end
      B_SINGLE, B_OFF: begin
        if (ld) begin
          st_nxt = B_IDLE;
        end
      end
      B_ENABLE: begin
        if (ld) begin
          st_nxt = (cnt_r != '0) ? B_LOW : B_IDLE;
        end
      end
      B_LOW: begin
        if (ld) begin
          st_nxt = B_HIGH;
        end
      end
      B_HIGH: begin
        if (ld) begin
          st_nxt = (cnt_r == 6'd1) ? B_IDLE : B_LOW;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    emit     = 1'b0;
    cnt_nxt  = cnt_r;
    sts_nxt  = sts_r;
    drv_nxt  = drv_r;
    pin_nxt  = pin_r;
    hold_nxt = hold_r;
    ost_nxt  = ost_r;
    last_nxt = last_r;
    case (st_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          pop     = 1'b1;
          cnt_nxt = pop_plan.pulses;
          sts_nxt = (pop_plan.kind == PK_STATUS) ? pop_plan.status : 1'b0;
        end
      end
      B_SINGLE: begin
        emit     = ld;
        drv_nxt  = 1'b0;
        pin_nxt  = 1'b0;
        hold_nxt = HOLD_NONE;
        ost_nxt  = sts_r;
        last_nxt = 1'b1;
      end
      B_OFF: begin
        emit     = ld;
        drv_nxt  = 1'b1;
        pin_nxt  = 1'b0;
        hold_nxt = HOLD_OFF_US;
        ost_nxt  = 1'b0;
        last_nxt = 1'b1;
      end
      B_ENABLE: begin
        emit     = ld;
        drv_nxt  = 1'b1;
        pin_nxt  = 1'b1;
        hold_nxt = HOLD_ENABLE_US;
        ost_nxt  = 1'b0;
        last_nxt = (cnt_r == '0);
      end
      B_LOW: begin
        emit     = ld;
        drv_nxt  = 1'b1;
        pin_nxt  = 1'b0;
        hold_nxt = HOLD_NONE;
        ost_nxt  = 1'b0;
        last_nxt = 1'b0;
      end
      B_HIGH: begin
        emit     = ld;
        drv_nxt  = 1'b1;
        pin_nxt  = 1'b1;
        hold_nxt = HOLD_NONE;
        ost_nxt  = 1'b0;
        last_nxt = (cnt_r == 6'd1);
        if (ld) begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    // Keep the payload while the receiver stalls
    if (!emit) begin
      drv_nxt  = drv_r;
      pin_nxt  = pin_r;
      hold_nxt = hold_r;
      ost_nxt  = ost_r;
      last_nxt = last_r;
    end
    vld_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= B_IDLE;
      vld_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    sts_r  <= sts_nxt;
    drv_r  <= drv_nxt;
    pin_r  <= pin_nxt;
    hold_r <= hold_nxt;
    ost_r  <= ost_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = vld_r;
  assign out_drives = drv_r;
  assign out_pin    = pin_r;
  assign out_hold   = hold_r;
  assign out_status = ost_r;
  assign out_last   = last_r;

  a_pulses_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_LOW || st_r == B_HIGH) |-> (cnt_r != '0))
    else $error("pulse state entered with no pulses left");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (st_r != B_IDLE))
    else $error("plan popped but sequencer stayed idle");

endmodule

FILE: design/pulse_count_dimming_driver_unit.sv
// Pulse-count dimming driver for a one-wire LED pin; step count on the APB port.
// Channels: in_tuser carries the command code, in_tdata the target level;
//   each result carries drives_pin on out_tuser, pin level, hold time and
//   status on out_tdata and the final-result mark on out_tlast.
// Commands are set level, on (full if dark) and off (if lit); a set above
//   the step count gives one result with status 1.
// Front end: a command is accepted when in_tready is high; status and off
//   commands go straight to the push state, dimming commands first run the
//   seven-step remainder sweep for the pulse count; a push waits on a full queue.
// A two-entry plan queue lets the front take the next command while the
//   sequencer still emits the pin actions of earlier ones.
// Sequencer: pops a plan, then emits one result per cycle while the receiver
//   accepts, up to 63 results per command, and pops the next plan only after
//   the last result of the current one.
// Each result passes the front states, the plan queue, the sequencer states
//   and the output register before out_tvalid rises.
// A stalled receiver holds the output register; the sequencer waits, the
//   queue fills and then in_tready stays low.
// Reset (rst_n, synchronous, active low) empties the queue, drops any pending
//   result, clears the level and sets the step count to 16; write it only when idle.
module pulse_count_dimming_driver_unit import pcdd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [5:0] target_level, [7:6] zero
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] pin_level, [12:1] hold_us, [13] status, [15:14] zero
  output logic [0:0]  out_tuser,  // [0] drives_pin
  output logic        out_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [LEVEL_W-1:0] step_r, step_nxt;
  logic               cfg_wr;

  q_stat_t            q_stat;
  logic               push;
  plan_t              push_plan;
  logic               pop;
  plan_t              pop_plan;

  logic               o_drives;
  logic               o_pin;
  logic [HOLD_W-1:0]  o_hold;
  logic               o_status;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign step_nxt = (cfg_wr && paddr[2] == CFG_REG_STEP[0]) ? pwdata[LEVEL_W-1:0] : step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == CFG_REG_STEP[0]) begin
      prdata = {{(32-LEVEL_W){1'b0}}, step_r};
    end
  end

  pcdd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tuser),
    .in_target  (in_tdata[LEVEL_W-1:0]),
    .step_count (step_r),
    .q_stat     (q_stat),
    .push       (push),
    .push_plan  (push_plan)
  );

  pcdd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_plan (push_plan),
    .pop       (pop),
    .pop_plan  (pop_plan),
    .q_stat    (q_stat)
  );

  pcdd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .pop_plan   (pop_plan),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_drives (o_drives),
    .out_pin    (o_pin),
    .out_hold   (o_hold),
    .out_status (o_status),
    .out_last   (out_tlast)
  );

  assign out_tdata = {2'b00, o_status, o_hold, o_pin};
  assign out_tuser = o_drives;

endmodule
